// File: sv/midi_track_event_parser_core_defines.svh
// Assertion macros for the MIDI track event parser.
// Included by the modules that check their own logic; expects clk and rst in scope.
`ifndef MIDI_TRACK_EVENT_PARSER_CORE_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MTEP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MTEP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/mtep_pkg.sv
// Shared types and constants of the MIDI track event parser.
// Used by mtep_step, mtep_skid and midi_track_event_parser_core; no dependencies.
package mtep_pkg;

  typedef enum logic [11:0] {
    PH_DELTA      = 12'b0000_0000_0001,
    PH_STATUS     = 12'b0000_0000_0010,
    PH_META_TYPE  = 12'b0000_0000_0100,
    PH_META_LEN   = 12'b0000_0000_1000,
    PH_TEXT       = 12'b0000_0001_0000,
    PH_TEMPO      = 12'b0000_0010_0000,
    PH_SKIP       = 12'b0000_0100_0000,
    PH_SYSEX_LEN  = 12'b0000_1000_0000,
    PH_SYSEX_HEAD = 12'b0001_0000_0000,
    PH_PROGRAM    = 12'b0010_0000_0000,
    PH_CTRL_NUM   = 12'b0100_0000_0000,
    PH_CTRL_VAL   = 12'b1000_0000_0000
  } phase_t;

  typedef enum logic [2:0] {
    KIND_PROGRAM = 3'd0,
    KIND_BANK    = 3'd1,
    KIND_TEMPO   = 3'd2,
    KIND_MARKER  = 3'd3,
    KIND_TEXT    = 3'd4,
    KIND_NAME    = 3'd5,
    KIND_SYSEX   = 3'd6,
    KIND_END     = 3'd7
  } event_kind_t;

  localparam logic [7:0] STATUS_META   = 8'hFF;
  localparam logic [3:0] TYPE_SYSEX    = 4'hF;
  localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
  localparam logic [3:0] TYPE_CTRL     = 4'hB;
  localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
  localparam logic [3:0] TYPE_POLY_AT  = 4'hA;
  localparam logic [3:0] TYPE_BEND     = 4'hE;
  localparam logic [7:0] META_TEXT     = 8'h01;
  localparam logic [7:0] META_NAME     = 8'h03;
  localparam logic [7:0] META_MARKER   = 8'h06;
  localparam logic [7:0] META_TEMPO    = 8'h51;
  localparam logic [7:0] META_END      = 8'h2F;
  localparam logic [23:0] CTRL_BANK_MSB = 24'd0;
  localparam logic [23:0] CTRL_BANK_LSB = 24'd32;

  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] tick;
    logic [7:0]  run_status;
    logic [7:0]  cur_status;
    phase_t      phase;
    logic [27:0] acc;
    logic [2:0]  qbc;
    logic [7:0]  meta;
    logic [31:0] remaining;
    logic [23:0] coll;
    logic        finished;
  } parse_state_t;

  typedef struct packed {
    event_kind_t kind;
    logic [31:0] tick;
    logic [3:0]  channel;
    logic [7:0]  value_a;
    logic [7:0]  value_b;
    logic [7:0]  value_c;
    logic [23:0] tempo_us;
    logic [27:0] length;
    logic [31:0] end_offset;
    logic        last;
  } event_t;

endpackage

// File: sv/mtep_step.sv
// Next-state and event logic of the MIDI track parser for one track byte.
// Depends on mtep_pkg for the parse state, phase and event types.
module mtep_step (
  input  mtep_pkg::parse_state_t st,
  input  logic [31:0]            track_length,
  input  logic [7:0]             data_byte,
  input  logic                   track_start,
  output mtep_pkg::parse_state_t nxt,
  output logic                   res_valid,
  output mtep_pkg::event_t       res
);

  function automatic mtep_pkg::phase_t status_phase(input logic [7:0] s);
    mtep_pkg::phase_t ph;
    if (s == mtep_pkg::STATUS_META) begin
      ph = mtep_pkg::PH_META_TYPE;
    end else if (s[7:4] == mtep_pkg::TYPE_SYSEX) begin
      ph = mtep_pkg::PH_SYSEX_LEN;
    end else if (s[7:4] == mtep_pkg::TYPE_PROGRAM) begin
      ph = mtep_pkg::PH_PROGRAM;
    end else if (s[7:4] == mtep_pkg::TYPE_CTRL) begin
      ph = mtep_pkg::PH_CTRL_NUM;
    end else begin
      ph = mtep_pkg::PH_SKIP;
    end
    return ph;
  endfunction

  // Data bytes that follow a channel status which is not decoded here.
  function automatic logic [31:0] status_skip(input logic [7:0] s);
    logic [31:0] n;
    if (s[7:4] == mtep_pkg::TYPE_NOTE_OFF || s[7:4] == mtep_pkg::TYPE_NOTE_ON ||
        s[7:4] == mtep_pkg::TYPE_POLY_AT || s[7:4] == mtep_pkg::TYPE_BEND) begin
      n = 32'd2;
    end else begin
      n = 32'd1;
    end
    return n;
  endfunction

  function automatic mtep_pkg::event_kind_t text_kind(input logic [7:0] m);
    mtep_pkg::event_kind_t k;
    if (m == mtep_pkg::META_MARKER) begin
      k = mtep_pkg::KIND_MARKER;
    end else if (m == mtep_pkg::META_TEXT) begin
      k = mtep_pkg::KIND_TEXT;
    end else begin
      k = mtep_pkg::KIND_NAME;
    end
    return k;
  endfunction

  mtep_pkg::parse_state_t base;
  mtep_pkg::parse_state_t eff;
  logic [27:0] acc_step;
  logic [2:0]  qbc_step;
  logic        vlq_done;
  logic [31:0] rem_dec;
  logic [23:0] coll_shift;
  logic [32:0] len_end;
  logic        meta_fits;
  logic        sysex_fits;
  logic        is_text;

  always_comb begin
    base = st;
    if (track_start) begin
      base            = '0;
      base.phase      = mtep_pkg::PH_DELTA;
    end

    // Running status: a data byte where a status is expected reuses the last one.
    eff = base;
    if (base.phase == mtep_pkg::PH_STATUS && !data_byte[7]) begin
      eff.cur_status = base.run_status;
      eff.qbc        = 3'd0;
      eff.phase      = status_phase(base.run_status);
      if (status_phase(base.run_status) == mtep_pkg::PH_SKIP) begin
        eff.remaining = status_skip(base.run_status);
      end
    end

    acc_step   = {((eff.qbc == 3'd0) ? 21'd0 : eff.acc[20:0]), data_byte[6:0]};
    qbc_step   = eff.qbc + 3'd1;
    vlq_done   = !data_byte[7] || (qbc_step >= 3'd4);
    rem_dec    = eff.remaining - 32'd1;
    coll_shift = {eff.coll[15:0], data_byte};
    len_end    = {1'b0, base.pos} + 33'd1 + {5'd0, acc_step};
    meta_fits  = !(len_end > {1'b0, track_length});
    sysex_fits = ({1'b0, base.pos} + 33'd4) < {1'b0, track_length};
    is_text    = (eff.meta == mtep_pkg::META_MARKER) || (eff.meta == mtep_pkg::META_TEXT) ||
                 (eff.meta == mtep_pkg::META_NAME);

    nxt       = base;
    res_valid = 1'b0;
    res       = '0;
    res.tick  = base.tick;

    if (!base.finished) begin
      if (base.pos >= track_length) begin
        nxt.finished = 1'b1;
      end else begin
        nxt     = eff;
        nxt.pos = base.pos + 32'd1;
        case (eff.phase)
          mtep_pkg::PH_STATUS: begin
            nxt.run_status = data_byte;
            nxt.cur_status = data_byte;
            nxt.qbc        = 3'd0;
            nxt.phase      = status_phase(data_byte);
            if (status_phase(data_byte) == mtep_pkg::PH_SKIP) begin
              nxt.remaining = status_skip(data_byte);
            end
          end
          mtep_pkg::PH_META_TYPE: begin
            nxt.meta  = data_byte;
            nxt.qbc   = 3'd0;
            nxt.phase = mtep_pkg::PH_META_LEN;
          end
          mtep_pkg::PH_META_LEN: begin
            nxt.acc = acc_step;
            nxt.qbc = vlq_done ? 3'd0 : qbc_step;
            if (vlq_done) begin
              if (!meta_fits) begin
                nxt.finished = 1'b1;
              end else if (is_text) begin
                if (acc_step == 28'd0) begin
                  nxt.phase     = mtep_pkg::PH_DELTA;
                  res_valid     = 1'b1;
                  res.kind      = text_kind(eff.meta);
                  res.last      = 1'b1;
                end else begin
                  nxt.remaining = {4'd0, acc_step};
                  nxt.phase     = mtep_pkg::PH_TEXT;
                end
              end else if (eff.meta == mtep_pkg::META_TEMPO && acc_step >= 28'd3) begin
                nxt.remaining = {4'd0, acc_step};
                nxt.coll      = 24'd0;
                nxt.phase     = mtep_pkg::PH_TEMPO;
              end else if (eff.meta == mtep_pkg::META_END) begin
                nxt.finished   = 1'b1;
                res_valid      = 1'b1;
                res.kind       = mtep_pkg::KIND_END;
                res.end_offset = base.pos + {4'd0, acc_step} - 32'd1;
              end else begin
                nxt.remaining = {4'd0, acc_step};
                nxt.phase     = (acc_step == 28'd0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
              end
            end
          end
          mtep_pkg::PH_TEXT: begin
            nxt.remaining = rem_dec;
            res_valid     = 1'b1;
            res.kind      = text_kind(eff.meta);
            res.value_a   = data_byte;
            res.length    = eff.acc;
            res.last      = (rem_dec == 32'd0);
            if (rem_dec == 32'd0) begin
              nxt.phase = mtep_pkg::PH_DELTA;
            end
          end
          mtep_pkg::PH_TEMPO, mtep_pkg::PH_SYSEX_HEAD: begin
            nxt.coll      = coll_shift;
            nxt.remaining = rem_dec;
            nxt.qbc       = qbc_step;
            if (qbc_step >= 3'd3) begin
              nxt.qbc   = 3'd0;
              nxt.phase = (rem_dec == 32'd0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
              res_valid = 1'b1;
              if (eff.phase == mtep_pkg::PH_TEMPO) begin
                res.kind     = mtep_pkg::KIND_TEMPO;
                res.tempo_us = coll_shift;
              end else begin
                res.kind    = mtep_pkg::KIND_SYSEX;
                res.channel = eff.cur_status[3:0];
                res.value_a = coll_shift[23:16];
                res.value_b = coll_shift[15:8];
                res.value_c = coll_shift[7:0];
                res.length  = eff.acc;
              end
            end
          end
          mtep_pkg::PH_SKIP: begin
            nxt.remaining = rem_dec;
            if (rem_dec == 32'd0) begin
              nxt.phase = mtep_pkg::PH_DELTA;
            end
          end
          mtep_pkg::PH_SYSEX_LEN: begin
            nxt.acc = acc_step;
            nxt.qbc = vlq_done ? 3'd0 : qbc_step;
            if (vlq_done) begin
              nxt.remaining = {4'd0, acc_step};
              if (acc_step >= 28'd3 && sysex_fits) begin
                nxt.coll  = 24'd0;
                nxt.phase = mtep_pkg::PH_SYSEX_HEAD;
              end else begin
                nxt.phase = (acc_step == 28'd0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
              end
            end
          end
          mtep_pkg::PH_PROGRAM: begin
            nxt.phase   = mtep_pkg::PH_DELTA;
            res_valid   = 1'b1;
            res.kind    = mtep_pkg::KIND_PROGRAM;
            res.channel = eff.cur_status[3:0];
            res.value_a = data_byte;
          end
          mtep_pkg::PH_CTRL_NUM: begin
            nxt.coll  = {16'd0, data_byte};
            nxt.phase = mtep_pkg::PH_CTRL_VAL;
          end
          mtep_pkg::PH_CTRL_VAL: begin
            nxt.phase = mtep_pkg::PH_DELTA;
            if (eff.coll == mtep_pkg::CTRL_BANK_MSB || eff.coll == mtep_pkg::CTRL_BANK_LSB) begin
              res_valid   = 1'b1;
              res.kind    = mtep_pkg::KIND_BANK;
              res.channel = eff.cur_status[3:0];
              res.value_a = eff.coll[7:0];
              res.value_b = data_byte;
            end
          end
          default: begin
            // Delta time; unknown phase codes land here too.
            nxt.acc = acc_step;
            if (vlq_done) begin
              nxt.qbc   = 3'd0;
              nxt.tick  = base.tick + {4'd0, acc_step};
              nxt.phase = mtep_pkg::PH_STATUS;
            end else begin
              nxt.qbc   = qbc_step;
              nxt.phase = mtep_pkg::PH_DELTA;
            end
          end
        endcase
      end
    end
  end

endmodule

// File: sv/mtep_skid.sv
// Output register with one skid entry for parser events.
// Depends on mtep_pkg for the event type.
module mtep_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mtep_pkg::event_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output mtep_pkg::event_t out_data
);

  logic             skid_valid;
  mtep_pkg::event_t skid_data;
  logic             out_fire;

  assign out_fire = out_valid && !out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        // Input is held off while the skid entry is in use.
        if (out_fire) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (push) begin
        if (!out_valid || out_fire) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (!out_valid || out_fire) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

// File: sv/midi_track_event_parser_core.sv
// Output: an event from a taken byte is registered in the output register or skid entry.
// Throughput: one track byte per cycle; the byte path is a single pass of parse logic
// between the parse state registers and the output register, backed by one skid entry.
// Input stalls only while both the output register and the skid entry hold events.
// Reset (rst, synchronous): clears track_length, the parse state and all valid flags;
// no clearing pass, the block takes bytes in the cycle after reset.
// Top level of the MIDI track event parser; depends on mtep_pkg, mtep_step, mtep_skid
// and the assertion macros in midi_track_event_parser_core_defines.svh.
`include "midi_track_event_parser_core_defines.svh"

module midi_track_event_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        track_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_kind,
  output logic [31:0] tick,
  output logic [3:0]  channel,
  output logic [7:0]  value_a,
  output logic [7:0]  value_b,
  output logic [7:0]  value_c,
  output logic [23:0] tempo_us,
  output logic [27:0] event_length,
  output logic [31:0] end_offset,
  output logic        text_last
);

  logic [31:0]            track_length;
  mtep_pkg::parse_state_t st;
  mtep_pkg::parse_state_t st_next;
  logic                   res_valid;
  mtep_pkg::event_t       res;
  mtep_pkg::event_t       out_data;
  logic                   skid_full;
  logic                   accept;
  logic                   push;
  logic                   stopped_take;
  logic                   end_take;

  assign in_stall     = skid_full;
  assign accept       = in_valid && !in_stall;
  assign push         = accept && res_valid;
  assign stopped_take = accept && st.finished && !track_start;
  assign end_take     = push && res.kind == mtep_pkg::KIND_END;

  always_ff @(posedge clk) begin
    if (rst) begin
      track_length <= 32'd0;
    end else if (cfg_wr_en) begin
      track_length <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: mtep_pkg::PH_DELTA, default: '0};
    end else if (accept) begin
      st <= st_next;
    end
  end

  mtep_step u_step (
    .st           (st),
    .track_length (track_length),
    .data_byte    (data_byte),
    .track_start  (track_start),
    .nxt          (st_next),
    .res_valid    (res_valid),
    .res          (res)
  );

  mtep_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .full      (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign event_kind   = out_data.kind;
  assign tick         = out_data.tick;
  assign channel      = out_data.channel;
  assign value_a      = out_data.value_a;
  assign value_b      = out_data.value_b;
  assign value_c      = out_data.value_c;
  assign tempo_us     = out_data.tempo_us;
  assign event_length = out_data.length;
  assign end_offset   = out_data.end_offset;
  assign text_last    = out_data.last;

  `MTEP_ASSERT_SAME(a_stall_needs_output, in_stall, out_valid, "input stalled with output empty")
  `MTEP_ASSERT_SAME(a_stopped_is_silent, stopped_take, !res_valid, "event after parser stopped")
  `MTEP_ASSERT_NEXT(a_end_stops, end_take, st.finished, "end of track did not stop parser")
  `MTEP_ASSERT_NEXT(a_event_reaches_output, push, out_valid, "accepted event not presented")

endmodule
